// File: rtl/core/b64enc_pkg.sv
`default_nettype none

package b64enc_pkg;

    // Pad character '='
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Position of the final character within a four-character group
    localparam logic [1:0] LAST_POS = 2'd3;

    // Number of bytes carried by a group
    localparam logic [1:0] NBYTES_ONE   = 2'd1;
    localparam logic [1:0] NBYTES_TWO   = 2'd2;
    localparam logic [1:0] NBYTES_THREE = 2'd3;

    // One gathered group of up to three bytes, first byte in bits 23..16
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;
        logic        last;
    } group_t;

    // Map a 6-bit value onto the standard base64 alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        c = {2'b00, v};
        if (v < 6'd26)
            return c + 8'h41;
        else if (v < 6'd52)
            return c + 8'h47;
        else if (v < 6'd62)
            return c - 8'd4;
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/b64enc_front.sv
`default_nettype none

module b64enc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_last,
    input  wire logic                 q_full,
    output logic                      push,
    output b64enc_pkg::group_t        push_group
);

    logic [15:0] held_bytes_reg;
    logic [15:0] held_bytes_next;
    logic [1:0]  held_count_reg;
    logic [1:0]  held_count_next;
    logic        accept;
    logic        closes;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign closes   = (held_count_reg == 2'd2) || in_last;
    assign push     = accept && closes;

    // Build the group from held bytes plus the incoming item
    always_comb
    begin
        push_group.last   = in_last;
        push_group.nbytes = held_count_reg + 2'd1;
        case (held_count_reg)
            2'd0:
            begin
                push_group.bits = {in_byte, 16'h0000};
            end
            2'd1:
            begin
                push_group.bits = {held_bytes_reg[15:8], in_byte, 8'h00};
            end
            default:
            begin
                push_group.bits = {held_bytes_reg, in_byte};
            end
        endcase
    end

    // Hold bytes until the group closes
    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (accept)
        begin
            if (closes)
            begin
                held_bytes_next = 16'h0000;
                held_count_next = 2'd0;
            end
            else if (held_count_reg == 2'd0)
            begin
                held_bytes_next = {in_byte, 8'h00};
                held_count_next = 2'd1;
            end
            else
            begin
                held_bytes_next = {held_bytes_reg[15:8], in_byte};
                held_count_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= 16'h0000;
            held_count_reg <= 2'd0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("front holds more than two bytes");
`endif

endmodule

`default_nettype wire

// File: rtl/core/b64enc_queue.sv
`default_nettype none

module b64enc_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire b64enc_pkg::group_t   push_group,
    output logic                      full,
    output logic                      head_valid,
    output b64enc_pkg::group_t        head_group,
    input  wire logic                 pop
);

    b64enc_pkg::group_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_group = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed groups
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/core/b64enc_back.sv
`default_nettype none

module b64enc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  wire b64enc_pkg::group_t   head_group,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_char,
    output logic                      out_last
);

    b64enc_pkg::group_t group_reg;
    b64enc_pkg::group_t group_next;
    logic       active_reg;
    logic       active_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_char_reg;
    logic [7:0] out_char_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       load_out;
    logic [7:0] cur_char;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign load_out  = !out_valid_reg || out_ready;

    // Select the character at the current position, with padding
    always_comb
    begin
        case (idx_reg)
            2'd0:
            begin
                cur_char = b64enc_pkg::sextet_char(group_reg.bits[23:18]);
            end
            2'd1:
            begin
                cur_char = b64enc_pkg::sextet_char(group_reg.bits[17:12]);
            end
            2'd2:
            begin
                cur_char = (group_reg.nbytes == b64enc_pkg::NBYTES_ONE)
                    ? b64enc_pkg::PAD_CHAR
                    : b64enc_pkg::sextet_char(group_reg.bits[11:6]);
            end
            default:
            begin
                cur_char = (group_reg.nbytes == b64enc_pkg::NBYTES_THREE)
                    ? b64enc_pkg::sextet_char(group_reg.bits[5:0])
                    : b64enc_pkg::PAD_CHAR;
            end
        endcase
    end

    // Emit one character per free output slot, fetch the next group at the end
    always_comb
    begin
        group_next     = group_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (load_out)
        begin
            if (active_reg)
            begin
                out_valid_next = 1'b1;
                out_char_next  = cur_char;
                out_last_next  = group_reg.last && (idx_reg == b64enc_pkg::LAST_POS);
                if (idx_reg == b64enc_pkg::LAST_POS)
                begin
                    idx_next    = 2'd0;
                    active_next = head_valid;
                    pop         = head_valid;
                    group_next  = head_group;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
                active_next    = head_valid;
                pop            = head_valid;
                group_next     = head_group;
                idx_next       = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        group_reg    <= group_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTHESIS
    a_idx_active: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> active_reg)
        else $error("character position set while no group is loaded");
`endif

endmodule

`default_nettype wire

// File: rtl/core/base64_stream_encoder_core.sv
// Channel  | Dir | tdata (low bit up)  | tlast                  | tuser
// s_axis   | in  | data_byte[7:0]      | last_byte              | -
// m_axis   | out | code_char[7:0]      | last_char              | -
//
// Each three-byte group (or shorter group closed by tlast) yields four
// characters, one per cycle from the back-end output register while the
// receiver is ready. Input takes one item per cycle while the two-entry
// group queue has room; sustained input rate is set by the output. A
// closing byte's group passes the queue, the back-end group register and
// the output register, and waits further while earlier groups drain or the
// output stalls. Reset clears held bytes, the queue and the output valid.
`default_nettype none

module base64_stream_encoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] code_char
    output logic            m_tlast
);

    logic               q_full;
    logic               push;
    b64enc_pkg::group_t push_group;
    logic               head_valid;
    b64enc_pkg::group_t head_group;
    logic               pop;

    b64enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_group (push_group)
    );

    b64enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (q_full),
        .head_valid (head_valid),
        .head_group (head_group),
        .pop        (pop)
    );

    b64enc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_group (head_group),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire

// File: verif/base64_stream_encoder_core_tb.sv
`default_nettype none

module base64_stream_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS  = 340;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 16;

    // One expected output character
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } b64_char_t;

    // Receiver stall modes
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Encoder state mirrored by the predictor
    logic [15:0] held_bytes = 16'h0000;
    logic [1:0]  held_count = 2'd0;

    b64_char_t pending_chars[$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    int        burst_left     = 0;

    rx_mode_t  rx_mode    = RX_STREAM;
    int        rx_left    = 0;
    int        rx_tick    = 0;

    base64_stream_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        return b64_alphabet[v];
    endfunction

    // Predict the characters caused by one accepted byte
    task automatic encode_byte(input logic [7:0] b, input logic is_last);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        if (held_count < 2'd2 && !is_last)
        begin
            if (held_count == 2'd0)
                held_bytes = {b, 8'h00};
            else
                held_bytes[7:0] = b;
            held_count = held_count + 2'd1;
        end
        else
        begin
            case (held_count)
                2'd0:    {b0, b1, b2} = {b, 16'h0000};
                2'd1:    {b0, b1, b2} = {held_bytes[15:8], b, 8'h00};
                default: {b0, b1, b2} = {held_bytes, b};
            endcase
            pending_chars.push_back('{b64_char(b0[7:2]), 1'b0});
            pending_chars.push_back('{b64_char({b0[1:0], b1[7:4]}), 1'b0});
            pending_chars.push_back('{(held_count == 2'd0) ? b64enc_pkg::PAD_CHAR
                                      : b64_char({b1[3:0], b2[7:6]}), 1'b0});
            pending_chars.push_back('{(held_count == 2'd2) ? b64_char(b2[5:0])
                                      : b64enc_pkg::PAD_CHAR, is_last});
            held_bytes = 16'h0000;
            held_count = 2'd0;
        end
    endtask

    // Predict on every accepted input item
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            encode_byte(s_tdata, s_tlast);
    end

    // Check every accepted output item against the oldest expectation
    always @(posedge clk)
    begin
        b64_char_t exp_c;
        if (m_tvalid && m_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected char expected none actual %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                exp_c = pending_chars.pop_front();
                if (m_tdata !== exp_c.code)
                begin
                    mismatch_count++;
                    $display("%0t: code_char expected %h actual %h",
                             $time, exp_c.code, m_tdata);
                end
                if (m_tlast !== exp_c.last)
                begin
                    mismatch_count++;
                    $display("%0t: last_char expected %b actual %b",
                             $time, exp_c.last, m_tlast);
                end
            end
        end
    end

    // Stall the receiver on a changing pattern
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 120);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STREAM:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_tready <= (rx_tick % 4) != 0;
            default:     m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Send one item, opening a new burst after a random gap when due
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                s_tlast  <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_message(input logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // One-byte messages: two characters and two pads
    task automatic test_single_byte_messages();
        send_message('{8'h00});
        send_message('{8'hFF});
    endtask

    // Two-byte messages: three characters and one pad
    task automatic test_two_byte_messages();
        send_message('{8'h00, 8'h00});
        send_message('{8'hFF, 8'hFF});
    endtask

    // Last byte completes a full group, no pad
    task automatic test_full_groups();
        send_message('{8'h00, 8'h00, 8'h00});
        send_message('{8'hFF, 8'hFF, 8'hFF});
        send_message('{8'hFB, 8'hEF, 8'hBE});
    endtask

    // Full group followed by a padded tail in one message
    task automatic test_group_then_tail();
        send_message('{8'h4D, 8'h61, 8'h6E, 8'h2A});
    endtask

    // Random messages, mostly short, a few long
    task automatic test_random_messages();
        int         sent;
        int         len;
        logic [7:0] msg[$];
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 9);
            msg.delete();
            repeat (len) msg.push_back(8'($urandom));
            send_message(msg);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_byte_messages();
        test_two_byte_messages();
        test_full_groups();
        test_group_then_tail();
        test_random_messages();

        // Drain the encoder
        s_tvalid <= 1'b0;
        wait (pending_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
